### hdl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared widths, codes and word types of the sampled line rasterizer.
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int EXT_BITS   = ERR_BITS + 2;
  localparam int KEY_BITS   = 24;
  localparam int IDX_BITS   = 2;

  localparam logic [CFG_BITS-1:0] GRID_RESET = CFG_BITS'(1 << COORD_BITS);
  localparam logic [CFG_BITS-1:0] STEP_RESET = CFG_BITS'(1);

  // register indexes of the configuration port
  localparam logic [IDX_BITS-1:0] REG_GRID_WIDTH  = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_GRID_HEIGHT = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_SAMPLE_STEP = IDX_BITS'(2);

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef struct packed {
    logic [CFG_BITS-1:0] grid_width;
    logic [CFG_BITS-1:0] grid_height;
    logic [CFG_BITS-1:0] sample_step;
  } slr_cfg_t;

  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } slr_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] cell_key;
    logic                key_valid;
    logic                segment_done;
  } slr_result_t;

endpackage

### hdl/slr_cfg_regs.sv
// ----------------------------------------------------------------------------
// slr_cfg_regs
// Grid size and sample step registers behind a plain write port.
// ----------------------------------------------------------------------------
module slr_cfg_regs import slr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  output slr_cfg_t            cfg_o
);

  slr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:  cfg_d.grid_width  = cfg_data_i;
        REG_GRID_HEIGHT: cfg_d.grid_height = cfg_data_i;
        REG_SAMPLE_STEP: cfg_d.sample_step = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width  <= GRID_RESET;
      cfg_q.grid_height <= GRID_RESET;
      cfg_q.sample_step <= STEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/slr_walker.sv
// ----------------------------------------------------------------------------
// slr_walker
// Bresenham walk state and the step logic that visits one cell per step word.
// ----------------------------------------------------------------------------
module slr_walker import slr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  slr_item_t   item_i,
  input  slr_cfg_t    cfg_i,
  output slr_result_t result_o,
  output logic        active_o
);

  logic [COORD_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [COORD_BITS-1:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic                  dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic [COORD_BITS-1:0] span_x_q, span_x_d, span_y_q, span_y_d;
  logic [ERR_BITS-1:0]   error_q, error_d;
  logic [COORD_BITS-1:0] phase_q, phase_d;
  logic                  active_q, active_d;

  logic                         at_end, in_grid;
  logic [CFG_BITS-1:0]          step_eff;
  logic [COORD_BITS+CFG_BITS-1:0] prod;
  logic [KEY_BITS-1:0]          key;
  logic signed [EXT_BITS-1:0]   e_ext, twice, sx, neg_sy, e_new;
  logic                         move_x, move_y;
  logic [CFG_BITS-1:0]          phase_next;
  logic                         x_fwd, y_fwd;
  logic [COORD_BITS-1:0]        load_span_x, load_span_y;

  assign at_end   = (pos_x_q == goal_x_q) && (pos_y_q == goal_y_q);
  assign in_grid  = ({1'b0, pos_x_q} < cfg_i.grid_width) &&
                    ({1'b0, pos_y_q} < cfg_i.grid_height);
  assign step_eff = (cfg_i.sample_step == '0) ? CFG_BITS'(1) : cfg_i.sample_step;

  assign prod = (COORD_BITS+CFG_BITS)'(pos_x_q) * (COORD_BITS+CFG_BITS)'(cfg_i.grid_height);
  assign key  = KEY_BITS'(prod) + KEY_BITS'(pos_y_q);

  // error update works on a sign-extended copy so 2*e cannot overflow
  assign e_ext  = EXT_BITS'(signed'(error_q));
  assign twice  = e_ext <<< 1;
  assign sx     = signed'(EXT_BITS'(span_x_q));
  assign neg_sy = -signed'(EXT_BITS'(span_y_q));
  assign move_x = twice >= neg_sy;
  assign move_y = twice <= sx;
  assign e_new  = e_ext + (move_x ? neg_sy : '0) + (move_y ? sx : '0);

  assign phase_next = {1'b0, phase_q} + CFG_BITS'(1);

  assign x_fwd       = item_i.start_x < item_i.end_x;
  assign y_fwd       = item_i.start_y < item_i.end_y;
  assign load_span_x = x_fwd ? item_i.end_x - item_i.start_x : item_i.start_x - item_i.end_x;
  assign load_span_y = y_fwd ? item_i.end_y - item_i.start_y : item_i.start_y - item_i.end_y;

  always_comb begin
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    span_x_d    = span_x_q;
    span_y_d    = span_y_q;
    error_d     = error_q;
    phase_d     = phase_q;
    active_d    = active_q;
    result_o    = '0;
    if (item_i.func == FUNC_LOAD) begin
      pos_x_d     = item_i.start_x;
      pos_y_d     = item_i.start_y;
      goal_x_d    = item_i.end_x;
      goal_y_d    = item_i.end_y;
      dir_x_neg_d = !x_fwd;
      dir_y_neg_d = !y_fwd;
      span_x_d    = load_span_x;
      span_y_d    = load_span_y;
      error_d     = ERR_BITS'(load_span_x) - ERR_BITS'(load_span_y);
      phase_d     = '0;
      active_d    = 1'b1;
    end else if (active_q) begin
      if (in_grid && ((phase_q == '0) || at_end)) begin
        result_o.cell_key  = key;
        result_o.key_valid = 1'b1;
      end
      if (at_end) begin
        result_o.segment_done = 1'b1;
        active_d              = 1'b0;
      end else begin
        if (move_x) begin
          pos_x_d = dir_x_neg_q ? pos_x_q - COORD_BITS'(1) : pos_x_q + COORD_BITS'(1);
        end
        if (move_y) begin
          pos_y_d = dir_y_neg_q ? pos_y_q - COORD_BITS'(1) : pos_y_q + COORD_BITS'(1);
        end
        error_d = e_new[ERR_BITS-1:0];
        phase_d = (phase_next >= step_eff) ? '0 : phase_next[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      span_x_q    <= '0;
      span_y_q    <= '0;
      error_q     <= '0;
      phase_q     <= '0;
      active_q    <= 1'b0;
    end else if (fire_i) begin
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      span_x_q    <= span_x_d;
      span_y_q    <= span_y_d;
      error_q     <= error_d;
      phase_q     <= phase_d;
      active_q    <= active_d;
    end
  end

  assign active_o = active_q;

endmodule

### hdl/sampled_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// sampled_line_rasterizer_core
// Sampled Bresenham line walker with grid clipping and cell key output.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i/in_ready_o) carries one word per item: a load
//   word (func 0) sets up a segment, a step word (func 1) visits one cell.
//   output channel (out_valid_o/out_ready_i) returns exactly one word per
//   input word, in order: cell key, key valid flag and segment done flag.
//   configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i):
//   index 0 grid width, 1 grid height, 2 sample step; write only when idle.
// Timing:
//   a taken word sits in the input register and is processed into the
//   result register once that register is empty or being read.
//   one word per cycle sustained while out_ready_i stays high; the walk state
//   updates in the same cycle as the result register, so the next word sees it at once.
// Reset and stall:
//   reset clears the walk state (no segment loaded) and sets the registers
//   to grid 4096 x 4096, sample step 1. when out_ready_i is low the result
//   waits in the output register, one more word waits in the input register,
//   and in_ready_o drops after that.
// ----------------------------------------------------------------------------
module sampled_line_rasterizer_core import slr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KEY_BITS-1:0]   cell_key_o,
  output logic                  key_valid_o,
  output logic                  segment_done_o,
  input  logic                  cfg_we_i,
  input  logic [IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_BITS-1:0]   cfg_data_i
);

  slr_cfg_t    cfg;
  slr_item_t   item_q;
  slr_result_t res, res_q;
  logic        in_valid_q;
  logic        out_valid_q;
  logic        process;
  logic        active;

  assign process    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || process;

  slr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  slr_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (process),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res),
    .active_o (active)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{func: func_i, start_x: start_x_i, start_y: start_y_i,
                  end_x: end_x_i, end_y: end_y_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_key_o     = res_q.cell_key;
  assign key_valid_o    = res_q.key_valid;
  assign segment_done_o = res_q.segment_done;

`ifndef NO_ASSERTIONS
  // a load word never reports a key or a finished segment
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && item_q.func == FUNC_LOAD |=> out_valid_q && !key_valid_o && !segment_done_o)
    else $error("load word produced a key or done flag");

  // reaching the endpoint ends the segment
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && res.segment_done |=> !active)
    else $error("segment still active after done");

  // a step with no loaded segment gives an empty result
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && item_q.func == FUNC_STEP && !active |=> !key_valid_o && !segment_done_o)
    else $error("step without segment produced output");

  // a stalled result must not be overwritten
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !process)
    else $error("result register overwritten while stalled");
`endif

endmodule

### dv/tb_sampled_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// tb_sampled_line_rasterizer_core
// Self-checking bench for the sampled Bresenham line walker. A cycle-free
// walker model predicts one result word per accepted input word. The bench
// runs steps with no segment, directed segments, grid clipping, a step
// change mid-segment, register extremes, a long output hold-off and a long
// random mix of segment sequences, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_sampled_line_rasterizer_core;
  import slr_pkg::*;

  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TOTAL_WORDS    = 1250;
  localparam int HOLD_CYCLES    = 80;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic                  func_i         = FUNC_LOAD;
  logic [COORD_BITS-1:0] start_x_i      = '0;
  logic [COORD_BITS-1:0] start_y_i      = '0;
  logic [COORD_BITS-1:0] end_x_i        = '0;
  logic [COORD_BITS-1:0] end_y_i        = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [KEY_BITS-1:0]   cell_key_o;
  logic                  key_valid_o;
  logic                  segment_done_o;
  logic                  cfg_we_i       = 1'b0;
  logic [IDX_BITS-1:0]   cfg_index_i    = REG_GRID_WIDTH;
  logic [CFG_BITS-1:0]   cfg_data_i     = '0;

  sampled_line_rasterizer_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_key_o     (cell_key_o),
    .key_valid_o    (key_valid_o),
    .segment_done_o (segment_done_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // walker model state
  logic [CFG_BITS-1:0]          grid_w_q   = GRID_RESET;
  logic [CFG_BITS-1:0]          grid_h_q   = GRID_RESET;
  logic [CFG_BITS-1:0]          step_q     = STEP_RESET;
  logic [COORD_BITS-1:0]        cur_x, cur_y, dst_x, dst_y;
  logic [COORD_BITS-1:0]        run_x, run_y, phase_cnt;
  logic                         neg_x, neg_y, seg_live;
  logic signed [ERR_BITS-1:0]   err_acc;

  slr_result_t cell_queue[$];
  int          n_errors    = 0;
  int          n_sent      = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          rx_hold_req = 1'b0;

  initial begin
    cur_x = '0; cur_y = '0; dst_x = '0; dst_y = '0;
    run_x = '0; run_y = '0; phase_cnt = '0;
    neg_x = 1'b0; neg_y = 1'b0; seg_live = 1'b0; err_acc = '0;
  end

  // one result per word; a load only sets up the walk
  function automatic slr_result_t walk_cell(slr_item_t w);
    slr_result_t         r;
    logic                at_goal, in_grid;
    logic [CFG_BITS-1:0] step_n, nxt;
    logic [31:0]         key_full;
    int                  e, e2;
    r = '0;
    if (w.func == FUNC_LOAD) begin
      cur_x     = w.start_x;
      cur_y     = w.start_y;
      dst_x     = w.end_x;
      dst_y     = w.end_y;
      neg_x     = !(w.start_x < w.end_x);
      neg_y     = !(w.start_y < w.end_y);
      run_x     = neg_x ? w.start_x - w.end_x : w.end_x - w.start_x;
      run_y     = neg_y ? w.start_y - w.end_y : w.end_y - w.start_y;
      e         = int'(run_x) - int'(run_y);
      err_acc   = e[ERR_BITS-1:0];
      phase_cnt = '0;
      seg_live  = 1'b1;
      return r;
    end
    if (!seg_live) return r;

    at_goal = (cur_x == dst_x) && (cur_y == dst_y);
    in_grid = ({1'b0, cur_x} < grid_w_q) && ({1'b0, cur_y} < grid_h_q);
    step_n  = (step_q == '0) ? CFG_BITS'(1) : step_q;
    if (in_grid && (phase_cnt == '0 || at_goal)) begin
      key_full    = 32'(cur_x) * 32'(grid_h_q) + 32'(cur_y);
      r.cell_key  = key_full[KEY_BITS-1:0];
      r.key_valid = 1'b1;
    end
    if (at_goal) begin
      r.segment_done = 1'b1;
      seg_live       = 1'b0;
      return r;
    end

    e  = int'(err_acc);
    e2 = 2 * e;
    if (e2 >= -int'(run_y)) begin
      e     = e - int'(run_y);
      cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    if (e2 <= int'(run_x)) begin
      e     = e + int'(run_x);
      cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
    end
    err_acc = e[ERR_BITS-1:0];

    nxt       = {1'b0, phase_cnt} + 1'b1;
    phase_cnt = (nxt >= step_n) ? '0 : nxt[COORD_BITS-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 70) return 0;
    if (roll < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // valid stays high after acceptance so a back-to-back word needs one assignment
  task automatic send_word(logic f, int sx, int sy, int ex, int ey);
    slr_item_t w;
    int        gap;
    w.func    = f;
    w.start_x = sx[COORD_BITS-1:0];
    w.start_y = sy[COORD_BITS-1:0];
    w.end_x   = ex[COORD_BITS-1:0];
    w.end_y   = ey[COORD_BITS-1:0];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= w.func;
    start_x_i  <= w.start_x;
    start_y_i  <= w.start_y;
    end_x_i    <= w.end_x;
    end_y_i    <= w.end_y;
    do @(posedge clk_i); while (!in_ready_o);
    cell_queue.insert(cell_queue.size(), walk_cell(w));
    n_sent++;
  endtask

  // step words ignore their coordinates, so they carry noise
  task automatic send_steps(int n);
    repeat (n) send_word(FUNC_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  function automatic int seg_len(int sx, int sy, int ex, int ey);
    int dx, dy;
    dx = (sx > ex) ? sx - ex : ex - sx;
    dy = (sy > ey) ? sy - ey : ey - sy;
    return ((dx > dy) ? dx : dy) + 1;
  endfunction

  task automatic run_segment(int sx, int sy, int ex, int ey, int extra);
    send_word(FUNC_LOAD, sx, sy, ex, ey);
    send_steps(seg_len(sx, sy, ex, ey) + extra);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (cell_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(int w, int h, int s);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GRID_WIDTH;
    cfg_data_i  <= w[CFG_BITS-1:0];
    @(posedge clk_i);
    grid_w_q     = w[CFG_BITS-1:0];
    cfg_index_i <= REG_GRID_HEIGHT;
    cfg_data_i  <= h[CFG_BITS-1:0];
    @(posedge clk_i);
    grid_h_q     = h[CFG_BITS-1:0];
    cfg_index_i <= REG_SAMPLE_STEP;
    cfg_data_i  <= s[CFG_BITS-1:0];
    @(posedge clk_i);
    step_q       = s[CFG_BITS-1:0];
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // result side: checks each accepted word and shapes out_ready_i
  always @(posedge clk_i) begin : rx_side
    slr_result_t want;
    int          roll;
    if (out_valid_o && out_ready_i) begin
      if (cell_queue.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result word, expected none actual key %0d valid %0b done %0b",
                 $time, cell_key_o, key_valid_o, segment_done_o);
      end else begin
        want = cell_queue.pop_front();
        check_field("cell_key", want.cell_key, cell_key_o);
        check_field("key_valid", want.key_valid, key_valid_o);
        check_field("segment_done", want.segment_done, segment_done_o);
      end
    end
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      stall_left  = HOLD_CYCLES;
    end
    roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (rx_steady || roll >= 10) begin
      out_ready_i <= 1'b1;
    end else begin
      stall_left   = (roll < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_steps_without_segment();
    send_steps(2);
  endtask

  task automatic test_directed_segments();
    run_segment(4095, 4095, 4095, 4095, 1);   // start equals end, then a dead step
    run_segment(0, 0, 0, 0, 0);
    run_segment(4095, 0, 4093, 3, 0);
    run_segment(0, 4095, 3, 4093, 0);
    // a load in the middle of a walk replaces it
    send_word(FUNC_LOAD, 5, 5, 9, 7);
    send_steps(2);
    run_segment(7, 1, 7, 4, 0);
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  task automatic test_clipped_grid();
    int sx, sy;
    set_config(20, 12, 3);
    run_segment(15, 5, 25, 8, 0);
    run_segment(3, 14, 9, 6, 0);
    repeat (12) begin
      sx = $urandom_range(0, 30);
      sy = $urandom_range(0, 20);
      run_segment(sx, sy, clamp_coord(sx + $urandom_range(0, 20) - 10),
                  clamp_coord(sy + $urandom_range(0, 20) - 10), 0);
    end
  endtask

  // the phase keeps counting across the write, compare uses the new step
  task automatic test_step_change_mid_segment();
    send_word(FUNC_LOAD, 0, 0, 30, 10);
    send_steps(7);
    set_config(20, 12, 5);
    send_steps(seg_len(0, 0, 30, 10) - 7 + 1);
    set_config(4096, 4096, 4);
    send_word(FUNC_LOAD, 40, 2, 10, 9);
    send_steps(10);
    set_config(4096, 4096, 2);
    send_steps(seg_len(40, 2, 10, 9) - 10);
  endtask

  task automatic test_register_extremes();
    set_config(0, 4096, 1);
    run_segment(3, 4, 9, 2, 0);
    set_config(4096, 0, 2);
    run_segment(10, 0, 4, 5, 0);
    set_config(8191, 8191, 0);                // key wraps, zero step acts as one
    run_segment(4095, 4095, 4088, 4090, 1);
    run_segment(4000, 100, 4006, 97, 0);
    set_config(1, 1, 4096);
    run_segment(0, 0, 2, 0, 0);
    run_segment(0, 3, 0, 0, 0);
    set_config(4096, 4096, 8191);
    run_segment(2048, 1024, 2055, 1020, 0);
    set_config(4096, 4096, 4096);
    run_segment(100, 200, 90, 230, 0);
  endtask

  task automatic test_output_backpressure();
    set_config(4096, 4096, 2);
    tx_steady   = 1'b1;
    rx_hold_req = 1'b1;
    run_segment(100, 200, 130, 190, 0);
    tx_steady   = 1'b0;
  endtask

  function automatic int pick_extent();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 4096;
    if (roll < 70) return $urandom_range(1, 64);
    if (roll < 85) return $urandom_range(1, 4096);
    if (roll < 93) return 0;
    return $urandom_range(4097, 8191);
  endfunction

  function automatic int pick_step();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(1, 4);
    if (roll < 70) return 1;
    if (roll < 85) return $urandom_range(5, 12);
    if (roll < 93) return $urandom_range(13, 4096);
    if (roll < 97) return 0;
    return $urandom_range(4097, 8191);
  endfunction

  // small grids get segments near the origin so most cells land inside
  function automatic int pick_origin(logic [CFG_BITS-1:0] extent);
    if (extent != '0 && extent < 4000 && $urandom_range(0, 3) != 0)
      return $urandom_range(0, int'(extent) + 8);
    return $urandom_range(0, 4095);
  endfunction

  function automatic int pick_delta();
    int roll, mag;
    roll = $urandom_range(0, 99);
    if (roll < 70)      mag = $urandom_range(0, 8);
    else if (roll < 95) mag = $urandom_range(0, 40);
    else                mag = $urandom_range(0, 250);
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  task automatic test_random_walks();
    int roll, sx, sy, ex, ey;
    while (n_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 9) == 0) set_config(pick_extent(), pick_extent(), pick_step());
      tx_steady = ($urandom_range(0, 15) == 0);
      rx_steady = ($urandom_range(0, 15) == 0);
      sx   = pick_origin(grid_w_q);
      sy   = pick_origin(grid_h_q);
      ex   = clamp_coord(sx + pick_delta());
      ey   = clamp_coord(sy + pick_delta());
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        run_segment(sx, sy, ex, ey, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
      end else if (roll < 95) begin
        // cut short, the next load takes over
        send_word(FUNC_LOAD, sx, sy, ex, ey);
        send_steps($urandom_range(0, seg_len(sx, sy, ex, ey) - 1));
      end else begin
        send_steps($urandom_range(1, 3));
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_steps_without_segment();
    test_directed_segments();
    test_clipped_grid();
    test_step_change_mid_segment();
    test_register_extremes();
    test_output_backpressure();
    test_random_walks();
    wait_idle();
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/slr_pkg.sv
hdl/slr_cfg_regs.sv
hdl/slr_walker.sv
hdl/sampled_line_rasterizer_core.sv
dv/tb_sampled_line_rasterizer_core.sv
